### hw/rtl/irpdd_pkg.sv
// Shared types, constants and helpers for the IR pulse-distance decoder.
`default_nettype none

package irpdd_pkg;

  localparam int unsigned TS_W       = 32;
  localparam int unsigned BOUND_W    = 18;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned CODE32_W   = 32;
  localparam int unsigned CODE16_W   = 16;

  localparam logic [CNT_W-1:0] FULL_BITS = 6'd32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEADER_MIN = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEADER_MAX = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_MIN = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_MAX = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_MIN    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_MAX    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MIN   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MAX   = 4'd7;

  // Reset values, microseconds
  localparam logic [BOUND_W-1:0] RST_LEADER_MIN = 18'd4500;
  localparam logic [BOUND_W-1:0] RST_LEADER_MAX = 18'd5200;
  localparam logic [BOUND_W-1:0] RST_REPEAT_MIN = 18'd100000;
  localparam logic [BOUND_W-1:0] RST_REPEAT_MAX = 18'd120000;
  localparam logic [BOUND_W-1:0] RST_ONE_MIN    = 18'd2000;
  localparam logic [BOUND_W-1:0] RST_ONE_MAX    = 18'd2500;
  localparam logic [BOUND_W-1:0] RST_ZERO_MIN   = 18'd1000;
  localparam logic [BOUND_W-1:0] RST_ZERO_MAX   = 18'd1400;

  typedef enum logic {
    OP_EDGE = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef struct packed {
    logic [BOUND_W-1:0] leader_min;
    logic [BOUND_W-1:0] leader_max;
    logic [BOUND_W-1:0] repeat_min;
    logic [BOUND_W-1:0] repeat_max;
    logic [BOUND_W-1:0] one_min;
    logic [BOUND_W-1:0] one_max;
    logic [BOUND_W-1:0] zero_min;
    logic [BOUND_W-1:0] zero_max;
  } bounds_t;

  typedef struct packed {
    op_t             op;
    logic [TS_W-1:0] timestamp_us;
    logic            pin_high;
  } item_t;

  typedef struct packed {
    logic                frame_ready;
    logic [CODE32_W-1:0] code32;
    logic [CODE16_W-1:0] code16;
    logic                inverse_ok;
  } result_t;

  function automatic logic [7:0] rev8(input logic [7:0] b);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[k] = b[7-k];
    end
    return r;
  endfunction

  // Strict window test: lo < v < hi
  function automatic logic in_window(input logic [TS_W-1:0] v,
                                     input logic [BOUND_W-1:0] lo,
                                     input logic [BOUND_W-1:0] hi);
    return (v > TS_W'(lo)) && (v < TS_W'(hi));
  endfunction

endpackage

`default_nettype wire

### hw/rtl/irpdd_if.sv
// Channel interfaces: edge/read items, decoded results, register writes.
`default_nettype none

interface irpdd_in_if import irpdd_pkg::*; ();
  logic            valid;
  logic            ready;
  op_t             op;
  logic [TS_W-1:0] timestamp_us;
  logic            pin_high;

  modport source (output valid, op, timestamp_us, pin_high, input ready);
  modport sink   (input valid, op, timestamp_us, pin_high, output ready);
endinterface

interface irpdd_out_if import irpdd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                frame_ready;
  logic [CODE32_W-1:0] code32;
  logic [CODE16_W-1:0] code16;
  logic                inverse_ok;

  modport source (output valid, frame_ready, code32, code16, inverse_ok, input ready);
  modport sink   (input valid, frame_ready, code32, code16, inverse_ok, output ready);
endinterface

interface irpdd_cfg_if import irpdd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BOUND_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/irpdd_cfg_regs.sv
// Interval bound registers with their reset values.
`default_nettype none

module irpdd_cfg_regs import irpdd_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_en,
  input  wire logic [CFG_IDX_W-1:0] wr_idx,
  input  wire logic [BOUND_W-1:0]   wr_data,
  output bounds_t                   bounds
);

  bounds_t bounds_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bounds_r.leader_min <= RST_LEADER_MIN;
      bounds_r.leader_max <= RST_LEADER_MAX;
      bounds_r.repeat_min <= RST_REPEAT_MIN;
      bounds_r.repeat_max <= RST_REPEAT_MAX;
      bounds_r.one_min    <= RST_ONE_MIN;
      bounds_r.one_max    <= RST_ONE_MAX;
      bounds_r.zero_min   <= RST_ZERO_MIN;
      bounds_r.zero_max   <= RST_ZERO_MAX;
    end else if (wr_en) begin
      case (wr_idx)
        CFG_LEADER_MIN: bounds_r.leader_min <= wr_data;
        CFG_LEADER_MAX: bounds_r.leader_max <= wr_data;
        CFG_REPEAT_MIN: bounds_r.repeat_min <= wr_data;
        CFG_REPEAT_MAX: bounds_r.repeat_max <= wr_data;
        CFG_ONE_MIN:    bounds_r.one_min    <= wr_data;
        CFG_ONE_MAX:    bounds_r.one_max    <= wr_data;
        CFG_ZERO_MIN:   bounds_r.zero_min   <= wr_data;
        CFG_ZERO_MAX:   bounds_r.zero_max   <= wr_data;
        default: ;  // unknown index: dropped
      endcase
    end
  end

  assign bounds = bounds_r;

endmodule

`default_nettype wire

### hw/rtl/irpdd_core.sv
// Decoder state, interval classification and frame readout.
`default_nettype none

module irpdd_core import irpdd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic fire,
  input  item_t     item,
  input  bounds_t   bounds,
  output result_t   result
);

  logic [TS_W-1:0]     last_rise_r, last_rise_nxt;
  logic [CNT_W-1:0]    bit_count_r, bit_count_nxt;
  logic                receiving_r, receiving_nxt;
  logic [CODE32_W-1:0] frame_bits_r, frame_bits_nxt;

  logic [TS_W-1:0] diff;
  logic            is_edge, is_read, frame_avail;
  logic [7:0]      rb0, rb1, rb2, rb3;
  logic [15:0]     data16, check16;

  assign diff        = item.timestamp_us - last_rise_r;
  assign is_edge     = (item.op == OP_EDGE) && item.pin_high;
  assign is_read     = (item.op == OP_READ);
  assign frame_avail = (bit_count_r == FULL_BITS);

  always_comb begin
    last_rise_nxt  = last_rise_r;
    bit_count_nxt  = bit_count_r;
    receiving_nxt  = receiving_r;
    frame_bits_nxt = frame_bits_r;
    if (is_edge) begin
      last_rise_nxt = item.timestamp_us;
      if (diff > TS_W'(bounds.repeat_max)) begin
        frame_bits_nxt = '0;
      end else if (in_window(diff, bounds.leader_min, bounds.leader_max)) begin
        bit_count_nxt = '0;
        receiving_nxt = 1'b1;
      end else if (in_window(diff, bounds.repeat_min, bounds.repeat_max)) begin
        bit_count_nxt = FULL_BITS;
        receiving_nxt = 1'b0;
      end else begin
        if (receiving_r && (bit_count_r < FULL_BITS)) begin
          if (in_window(diff, bounds.one_min, bounds.one_max)) begin
            frame_bits_nxt[bit_count_r[4:0]] = 1'b1;
            bit_count_nxt = bit_count_r + 1'b1;
          end else if (in_window(diff, bounds.zero_min, bounds.zero_max)) begin
            frame_bits_nxt[bit_count_r[4:0]] = 1'b0;
            bit_count_nxt = bit_count_r + 1'b1;
          end
        end
        if (bit_count_nxt >= FULL_BITS) begin
          receiving_nxt = 1'b0;
        end
      end
    end else if (is_read && frame_avail) begin
      bit_count_nxt = '0;  // rearm
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_rise_r  <= '0;
      bit_count_r  <= '0;
      receiving_r  <= 1'b0;
      frame_bits_r <= '0;
    end else if (fire) begin
      last_rise_r  <= last_rise_nxt;
      bit_count_r  <= bit_count_nxt;
      receiving_r  <= receiving_nxt;
      frame_bits_r <= frame_bits_nxt;
    end
  end

  // Readout, each byte reversed
  assign rb0     = rev8(frame_bits_r[7:0]);
  assign rb1     = rev8(frame_bits_r[15:8]);
  assign rb2     = rev8(frame_bits_r[23:16]);
  assign rb3     = rev8(frame_bits_r[31:24]);
  assign data16  = {rb0, rb2};
  assign check16 = {~rb1, ~rb3};

  always_comb begin
    result = '0;
    if (is_read && frame_avail) begin
      result.frame_ready = 1'b1;
      result.code32      = {rb0, rb1, rb2, rb3};
      result.inverse_ok  = (data16 == check16);
      result.code16      = (data16 == check16) ? data16 : '0;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ir_pulse_distance_decoder_unit.sv
// Top level of the IR pulse-distance (NEC-style) frame decoder.
// Pipeline: input register, then decode logic, then result register.
// Throughput: one transaction per cycle while the result is not stalled; the decoder state updates once per item.
// Reset: rst_n synchronous, active low; clears pipeline valids and decoder state,
//   and loads the interval bounds with their default microsecond values.
`default_nettype none

module ir_pulse_distance_decoder_unit import irpdd_pkg::*; (
  input wire logic  clk,
  input wire logic  rst_n,
  irpdd_in_if.sink    in_ch,
  irpdd_out_if.source out_ch,
  irpdd_cfg_if.sink   cfg_ch
);

  // Configuration: always ready; the user must write it only while the decoder is idle, the block does not enforce it.
  bounds_t bounds;

  assign cfg_ch.ready = 1'b1;

  irpdd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_ch.valid),
    .wr_idx  (cfg_ch.index),
    .wr_data (cfg_ch.data),
    .bounds  (bounds)
  );

  // Input register stage. It moves on whenever the result register is
  // empty or being drained; intake stalls only while a result waits and
  // the input register is also full.
  logic    item_valid_r;
  item_t   item_r;
  logic    advance;
  logic    fire;
  result_t result;

  logic    out_valid_r;
  result_t out_r;

  assign advance     = !out_valid_r || out_ch.ready;
  assign fire        = item_valid_r && advance;
  assign in_ch.ready = !item_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      item_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.op           <= in_ch.op;
      item_r.timestamp_us <= in_ch.timestamp_us;
      item_r.pin_high     <= in_ch.pin_high;
    end
  end

  // Decode: state commits only when the item moves into the result register.
  irpdd_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (item_r),
    .bounds (bounds),
    .result (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= result;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.frame_ready = out_r.frame_ready;
  assign out_ch.code32      = out_r.code32;
  assign out_ch.code16      = out_r.code16;
  assign out_ch.inverse_ok  = out_r.inverse_ok;

endmodule

`default_nettype wire

### hw/rtl/irpdd_checker.sv
// Port-level assertions for the decoder, bound to the top level.
`default_nettype none

module irpdd_checker import irpdd_pkg::*; (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic                out_frame_ready,
  input wire logic [CODE32_W-1:0] out_code32,
  input wire logic [CODE16_W-1:0] out_code16,
  input wire logic                out_inverse_ok,
  input wire logic                cfg_ready
);

  // Stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_code32) && $stable(out_code16)
      && $stable(out_frame_ready) && $stable(out_inverse_ok))
    else $error("result changed while stalled");

  // No frame: every field is zero
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_ready |-> out_code32 == '0 && out_code16 == '0 && !out_inverse_ok)
    else $error("nonzero fields without a frame");

  // Failed check forces code16 to zero
  a_bad_check: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_inverse_ok |-> out_code16 == '0)
    else $error("code16 nonzero with failed inverse check");

  // Good check: code16 is address and command bytes of code32
  a_code16: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_inverse_ok |->
      out_code16 == {out_code32[31:24], out_code32[15:8]}
      && out_code32[23:16] == ~out_code32[31:24] && out_code32[7:0] == ~out_code32[15:8])
    else $error("code16 disagrees with code32");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind ir_pulse_distance_decoder_unit irpdd_checker u_irpdd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_frame_ready (out_ch.frame_ready),
  .out_code32      (out_ch.code32),
  .out_code16      (out_ch.code16),
  .out_inverse_ok  (out_ch.inverse_ok),
  .cfg_ready       (cfg_ch.ready)
);

`default_nettype wire
